### sv/rfpu_pkg.sv
// rfpu_pkg: shared types and constants for the reduced float pack/unpack core
// no dependencies
`default_nettype none
package rfpu_pkg;
  localparam int unsigned IeeeMantBits = 23;
  localparam int unsigned IeeeExpBits = 8;
  localparam logic [7:0] IeeeBias = 8'd127;

  typedef enum logic {
    OP_PACK = 1'b0,
    OP_UNPACK = 1'b1
  } op_t;

  typedef enum logic {
    REG_EXP_BITS = 1'b0,
    REG_MANT_BITS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] e;
    logic [4:0] m;
  } fmt_t;
endpackage
`default_nettype wire

### sv/rfpu_unpack.sv
// rfpu_unpack: rebuilds ieee single bits from a small float code
// depends on rfpu_pkg
`default_nettype none
module rfpu_unpack (
  input  wire logic [31:0]        code,
  input  wire rfpu_pkg::fmt_t     fmt,
  output logic [31:0]             ieee
);
  logic [5:0]  pos_s;
  logic [5:0]  pos_n;
  logic        sgn;
  logic        eneg;
  logic [7:0]  mag;
  logic [31:0] mant;
  logic [7:0]  biased;

  always_comb begin
    pos_s = 6'(fmt.e) + 6'(fmt.m);
    pos_n = pos_s - 6'd1;
    sgn = code[pos_s[4:0]];
    eneg = code[pos_n[4:0]];
    mag = 8'((code >> fmt.m) & ((32'd1 << (fmt.e - 4'd1)) - 32'd1));
    mant = (code & ((32'd1 << fmt.m) - 32'd1)) << (5'd23 - fmt.m);
    biased = eneg ? rfpu_pkg::IeeeBias - mag : rfpu_pkg::IeeeBias + mag;
    ieee = {sgn, biased, mant[22:0]};
  end
endmodule
`default_nettype wire

### sv/rfpu_pack.sv
// rfpu_pack: packs an ieee single into a small float code with clamping
// depends on rfpu_pkg
`default_nettype none
module rfpu_pack (
  input  wire logic [31:0]    f,
  input  wire rfpu_pkg::fmt_t fmt,
  output logic [31:0]         code
);
  logic [31:0] max_code;
  logic [31:0] min_code;
  logic [31:0] neg_flag;
  logic [30:0] kmax;
  logic [30:0] kmin;
  logic [30:0] kabs;
  logic        nan;
  logic [8:0]  ex;
  logic        eneg;
  logic [7:0]  mag;
  logic [31:0] plain;
  logic [3:0]  mb;
  logic [31:0] max_ieee;
  logic [31:0] min_ieee;

  // magnitudes of the clamp codes: max has exp +(2^mb-1), min has exp -(2^mb-2)
  always_comb begin
    mb = fmt.e - 4'd1;
    max_code = (((32'd1 << mb) - 32'd1) << fmt.m) | ((32'd1 << fmt.m) - 32'd1);
    min_code = (((32'd1 << fmt.e) - 32'd2) << fmt.m) | 32'd1;
    neg_flag = 32'd1 << (6'(fmt.e) + 6'(fmt.m));
    max_ieee = {1'b0, 8'(rfpu_pkg::IeeeBias + 8'((9'd1 << mb) - 9'd1)),
                23'(((32'd1 << fmt.m) - 32'd1) << (5'd23 - fmt.m))};
    min_ieee = {1'b0, 8'(rfpu_pkg::IeeeBias - 8'((9'd1 << mb) - 9'd2)),
                23'(32'd1 << (5'd23 - fmt.m))};
    kmax = max_ieee[30:0];
    kmin = min_ieee[30:0];
    kabs = f[30:0];
    nan = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    ex = {1'b0, f[30:23]} - {1'b0, rfpu_pkg::IeeeBias};
    eneg = ex[8];
    mag = eneg ? 8'(-ex) : ex[7:0];
    mag = mag & 8'((9'd1 << mb) - 9'd1);
    plain = ({31'd0, f[31]} << (6'(fmt.e) + 6'(fmt.m)))
          | ((({31'd0, eneg} << mb) | {24'd0, mag}) << fmt.m)
          | ({9'd0, f[22:0]} >> (5'd23 - fmt.m));
    code = plain;
    if (!nan) begin
      // a zero key counts as non-negative, so negative zero goes positive
      if (!f[31] || kabs == 31'd0) begin
        if (kabs >= kmax) code = max_code;
        else if (kabs <= kmin) code = min_code;
      end else begin
        if (kabs >= kmax) code = max_code | neg_flag;
        else if (kabs <= kmin) code = min_code | neg_flag;
      end
    end
  end
endmodule
`default_nettype wire

### sv/reduced_float_pack_unpack_core.sv
// reduced_float_pack_unpack_core: top level with config registers and word pipe
// depends on rfpu_pkg, rfpu_pack, rfpu_unpack
// pipeline: two register stages, input word register then result register; a stall can hold either
// throughput: one word per cycle while the output is not stalled, set by the single-pass convert logic
// input stalls only when both stages hold a word and the output is stalled
// reset: valids cleared, exponent_bits 5, mantissa_bits 10
`default_nettype none
module reduced_float_pack_unpack_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [0:0]  in_opcode,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_result
);
  logic [3:0]  exp_r;
  logic [4:0]  mant_r;
  logic        v1_r;
  logic        op1_r;
  logic [31:0] val1_r;
  logic        v2_r;
  logic [31:0] res2_r;
  rfpu_pkg::fmt_t fmt;
  logic [31:0] packed_w;
  logic [31:0] unpacked_w;
  logic        adv2;
  logic        adv1;

  always_comb begin
    fmt.e = (exp_r < 4'd2) ? 4'd2 : (exp_r > 4'd8) ? 4'd8 : exp_r;
    fmt.m = (mant_r < 5'd2) ? 5'd2 : (mant_r > 5'd23) ? 5'd23 : mant_r;
  end

  assign adv2 = !v2_r || !out_stall;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;
  assign out_valid = v2_r;
  assign out_result = res2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= 4'd5;
      mant_r <= 5'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        rfpu_pkg::REG_EXP_BITS: exp_r <= cfg_data[3:0];
        rfpu_pkg::REG_MANT_BITS: mant_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      op1_r <= in_opcode[0];
      val1_r <= in_value;
    end
    if (adv2 && v1_r) begin
      res2_r <= (op1_r == rfpu_pkg::OP_UNPACK) ? unpacked_w : packed_w;
    end
  end

  rfpu_pack u_pack (.f(val1_r), .fmt(fmt), .code(packed_w));
  rfpu_unpack u_unpack (.code(val1_r), .fmt(fmt), .ieee(unpacked_w));

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && out_stall |=> v2_r && $stable(res2_r)) else $error("result lost");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r) else $error("spurious stall");
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !out_stall |=> v2_r) else $error("word dropped");
endmodule
`default_nettype wire

### tb/reduced_float_pack_unpack_core_tb.sv
// testbench for reduced_float_pack_unpack_core: random and directed pack/unpack words
// checked against an in-bench conversion model; depends on rfpu_pkg and the core
`timescale 1ns / 100ps
`default_nettype none
module reduced_float_pack_unpack_core_tb;

  typedef struct packed {
    rfpu_pkg::op_t op;
    logic [31:0]   value;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [0:0]  in_opcode = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_result;

  reduced_float_pack_unpack_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_value(in_value), .out_valid(out_valid),
    .out_stall(out_stall), .out_result(out_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  word_t       pending_words[$];
  logic [31:0] expected_results[$];
  logic [3:0]  exp_width_reg;
  logic [4:0]  mant_width_reg;
  int          mismatches = 0;
  int          results_seen = 0;
  int          words_sent = 0;
  int          cycle_count = 0;
  int          drv_gap = 0;
  int          mon_gap = 0;
  bit          drv_hold = 1'b0;
  bit          in_taken = 1'b0;

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] unpack_small(logic [31:0] code, int unsigned e,
                                               int unsigned m);
    logic        sgn;
    logic        eneg;
    logic [31:0] mag;
    logic [31:0] mant;
    logic [31:0] biased;
    sgn = code[e + m];
    eneg = code[e + m - 1];
    mag = (code >> m) & ((32'd1 << (e - 1)) - 1);
    mant = (code & ((32'd1 << m) - 1)) << (rfpu_pkg::IeeeMantBits - m);
    biased = eneg ? 32'd127 - mag : 32'd127 + mag;
    return {sgn, biased[7:0], mant[22:0]};
  endfunction

  function automatic longint ordering(logic [31:0] b);
    longint mag;
    mag = longint'({1'b0, b[30:0]});
    return b[31] ? -mag : mag;
  endfunction

  function automatic logic [31:0] convert_word(word_t w, logic [3:0] er, logic [4:0] mr);
    int unsigned e;
    int unsigned m;
    int unsigned eb;
    logic [31:0] max_code;
    logic [31:0] min_code;
    logic [31:0] neg_flag;
    longint      k;
    longint      kmax;
    longint      kmin;
    int          ex;
    logic [31:0] mag;
    logic [31:0] v;
    e = (er < 2) ? 2 : (er > 8) ? 8 : er;
    m = (mr < 2) ? 2 : (mr > 23) ? 23 : mr;
    if (w.op == rfpu_pkg::OP_UNPACK) return unpack_small(w.value, e, m);
    eb = e - 1;
    max_code = (((32'd1 << eb) - 1) << m) | ((32'd1 << m) - 1);
    min_code = (((32'd1 << e) - 2) << m) | 32'd1;
    neg_flag = 32'd1 << (e + m);
    if (!(w.value[30:23] == 8'hFF && w.value[22:0] != 0)) begin
      k = ordering(w.value);
      kmax = ordering(unpack_small(max_code, e, m));
      kmin = ordering(unpack_small(min_code, e, m));
      if (k >= 0) begin
        if (k >= kmax) return max_code;
        if (k <= kmin) return min_code;
      end else begin
        if (k <= -kmax) return max_code | neg_flag;
        if (k >= -kmin) return min_code | neg_flag;
      end
    end
    ex = int'(w.value[30:23]) - 127;
    mag = 32'(ex < 0 ? -ex : ex) & ((32'd1 << eb) - 1);
    v = 32'(w.value[31]) << (e + m);
    v |= (((ex < 0 ? 32'd1 : 32'd0) << eb) | mag) << m;
    v |= 32'(w.value[22:0]) >> (rfpu_pkg::IeeeMantBits - m);
    return v;
  endfunction

  // input accept tracking
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(convert_word('{rfpu_pkg::op_t'(in_opcode), in_value},
                                              exp_width_reg, mant_width_reg));
      words_sent <= words_sent + 1;
    end
  end

  // driver
  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
    end else if (drv_gap > 0) begin
      drv_gap <= drv_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_words.size() > 0 && !drv_hold && rst_n) begin
      word_t w;
      w = pending_words.pop_front();
      in_valid <= 1'b1;
      in_opcode <= w.op;
      in_value <= w.value;
      drv_gap <= ($urandom_range(0, 3) == 0) ? rand_gap() : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_result);
        mismatches <= mismatches + 1;
      end else if (expected_results[0] !== out_result) begin
        $display("%0t: result mismatch, expected %h, actual %h", $time,
                 expected_results[0], out_result);
        mismatches <= mismatches + 1;
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (mon_gap > 0) begin
      mon_gap <= mon_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      mon_gap <= rand_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(rfpu_pkg::reg_idx_t idx, logic [4:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rfpu_pkg::REG_EXP_BITS) exp_width_reg = data[3:0];
    else mant_width_reg = data;
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    int unsigned pick;
    f = $urandom();
    pick = $urandom_range(0, 9);
    if (pick < 6) f[30:23] = 8'(127 + $urandom_range(0, 16) - 8);
    else if (pick == 6) f[30:23] = 8'(127 + $urandom_range(0, 300) - 150);
    else if (pick == 7) f[30:23] = 8'hFF;
    else if (pick == 8) f[30:0] = '0;
    return f;
  endfunction

  task automatic queue_phase(int n);
    word_t w;
    repeat (n) begin
      w.op = ($urandom_range(0, 1) == 0) ? rfpu_pkg::OP_PACK : rfpu_pkg::OP_UNPACK;
      w.value = (w.op == rfpu_pkg::OP_PACK) ? rand_float() : $urandom();
      if (w.op == rfpu_pkg::OP_UNPACK && $urandom_range(0, 1) == 0)
        w.value = convert_word('{rfpu_pkg::OP_PACK, rand_float()}, exp_width_reg,
                               mant_width_reg);
      pending_words.push_back(w);
    end
  endtask

  initial begin
    logic [31:0] directed[$];
    exp_width_reg = 4'd5;
    mant_width_reg = 5'd10;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0001, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h0000_0001,
                 32'h3F80_0000, 32'hBF80_0000, 32'h4780_0000, 32'h3800_0000};
    foreach (directed[i]) pending_words.push_back('{rfpu_pkg::OP_PACK, directed[i]});
    pending_words.push_back('{rfpu_pkg::OP_UNPACK, 32'h0000_0000});
    pending_words.push_back('{rfpu_pkg::OP_UNPACK, 32'hFFFF_FFFF});
    pending_words.push_back('{rfpu_pkg::OP_UNPACK, 32'h0000_4000});
    pending_words.push_back('{rfpu_pkg::OP_UNPACK, 32'h0000_7FFF});
    pending_words.push_back('{rfpu_pkg::OP_UNPACK, 32'h0000_83FF});
    drain();
    // mix of widths including out-of-range register values
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          write_reg(rfpu_pkg::REG_EXP_BITS, 5'd2);
          write_reg(rfpu_pkg::REG_MANT_BITS, 5'd2);
        end
        1: begin
          write_reg(rfpu_pkg::REG_EXP_BITS, 5'd8);
          write_reg(rfpu_pkg::REG_MANT_BITS, 5'd23);
        end
        2: begin
          write_reg(rfpu_pkg::REG_EXP_BITS, 5'd0);
          write_reg(rfpu_pkg::REG_MANT_BITS, 5'd31);
        end
        3: begin
          write_reg(rfpu_pkg::REG_EXP_BITS, 5'd15);
          write_reg(rfpu_pkg::REG_MANT_BITS, 5'd0);
        end
        4: begin
          write_reg(rfpu_pkg::REG_EXP_BITS, 5'd1);
          write_reg(rfpu_pkg::REG_MANT_BITS, 5'd24);
        end
        default: begin
          write_reg(rfpu_pkg::REG_EXP_BITS, 5'($urandom_range(0, 15)));
          write_reg(rfpu_pkg::REG_MANT_BITS, 5'($urandom_range(0, 31)));
        end
      endcase
      queue_phase(172);
      if (phase == 5) begin
        while (pending_words.size() > 80) @(posedge clk);
        drv_hold = 1'b1;
        while (in_valid || expected_results.size() > 0) @(posedge clk);
        drv_hold = 1'b0;
      end
      drain();
    end
    $display("sent %0d words, checked %0d results over ten width settings",
             words_sent, results_seen);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
